### rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

  localparam int unsigned MAX_BLOCKS = 4096;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned MAP_WORDS  = MAX_BLOCKS / WORD_BITS;
  localparam int unsigned WIDX_W     = $clog2(MAP_WORDS);
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned BLK_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned COUNT_W    = BLK_W + 1;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_FIND  = 2'd3
  } cmd_e;

  // per-word result of the first-fit scan
  typedef struct packed {
    logic               hit;
    logic [BIT_W-1:0]   idx;
    logic [COUNT_W-1:0] run_out;
  } fit_t;

endpackage

`default_nettype wire

### rtl/bba_if.sv
`default_nettype none

interface bba_cmd_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [BLK_W-1:0]   start_block;
  logic [COUNT_W-1:0] length;
  logic               polarity;

  modport source (output valid, command, start_block, length, polarity, input ready);
  modport sink   (input valid, command, start_block, length, polarity, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               check_ok;
  logic [COUNT_W-1:0] found_block;

  modport source (output valid, check_ok, found_block, input ready);
  modport sink   (input valid, check_ok, found_block, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] block_count;

  modport source (output valid, block_count, input ready);
  modport sink   (input valid, block_count, output ready);
endinterface

`default_nettype wire

### rtl/bba_fit_scan.sv
`default_nettype none

// Looks at one map word during the first-fit search. Given the free run that
// reaches the word from below, finds the first bit where a free run of the
// requested length ends, and the free run leaving the word at the top.
module bba_fit_scan import bba_pkg::*; (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [WIDX_W-1:0]    widx_i,
  input  logic [COUNT_W-1:0]   run_i,
  input  logic [COUNT_W-1:0]   len_i,
  input  logic [COUNT_W-1:0]   bc_i,
  output fit_t                 fit_o
);

  logic [WORD_BITS-1:0] lu_fnd;
  logic [BIT_W-1:0]     lu_idx [WORD_BITS];
  logic [WORD_BITS-1:0] hit;

  // highest used bit at or below each position
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      lu_fnd[i] = 1'b0;
      lu_idx[i] = '0;
      for (int j = 0; j <= i; j++) begin
        if (word_i[j]) begin
          lu_fnd[i] = 1'b1;
          lu_idx[i] = BIT_W'(j);
        end
      end
    end
  end

  always_comb begin
    logic [COUNT_W:0]   run_len;
    logic [COUNT_W-1:0] gpos;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lu_fnd[i]) begin
        run_len = (COUNT_W+1)'(BIT_W'(i) - lu_idx[i]);
      end else begin
        run_len = {1'b0, run_i} + (COUNT_W+1)'(i + 1);
      end
      gpos   = COUNT_W'({widx_i, BIT_W'(i)});
      hit[i] = !word_i[i] && (run_len >= {1'b0, len_i}) && (gpos < bc_i);
    end
  end

  always_comb begin
    fit_o.hit = |hit;
    fit_o.idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        fit_o.idx = BIT_W'(i);
      end
    end
    if (lu_fnd[WORD_BITS-1]) begin
      fit_o.run_out = COUNT_W'(BIT_W'(WORD_BITS - 1) - lu_idx[WORD_BITS-1]);
    end else begin
      fit_o.run_out = run_i + COUNT_W'(WORD_BITS);
    end
  end

endmodule

`default_nettype wire

### rtl/bitmap_block_allocator.sv
`default_nettype none

// First-fit bitmap block allocator. One used/free bit per block, held in a
// 128 x 32-bit single-port-read/single-port-write RAM, all blocks free after
// reset (per-word valid flops stand in for a clearing pass, so the block is
// ready at once). Commands are taken one at a time. set/clear/check walk the
// words the range touches at one word per cycle. find_and_set walks from word
// 0 at one word per cycle until a fitting run ends, then marks it with a set
// pass. Zero-length and empty ranges skip the word walk and go straight to
// the response. A new command is taken while the previous response still
// waits; block_count writes are taken at any time and saturate at 4096.
module bitmap_block_allocator import bba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bba_cfg_if.sink   cfg_i,
  bba_cmd_if.sink   cmd_i,
  bba_rsp_if.source rsp_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_FIND  = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [COUNT_W-1:0]   bc_q, bc_d;
  logic [1:0]           cmd_q, cmd_d;
  logic [BLK_W-1:0]     start_q, start_d;
  logic [COUNT_W-1:0]   len_q, len_d;
  logic                 pol_q, pol_d;
  logic [COUNT_W-1:0]   end_q, end_d;
  logic                 ok_q, ok_d;
  logic [COUNT_W-1:0]   found_q, found_d;
  logic [COUNT_W-1:0]   run_q, run_d;
  logic                 iss_q, iss_d;
  logic [WIDX_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [WIDX_W-1:0]    rd_word_q, rd_word_d;
  logic                 out_vld_q, out_vld_d;
  logic                 out_ok_q, out_ok_d;
  logic [COUNT_W-1:0]   out_found_q, out_found_d;
  logic [MAP_WORDS-1:0] map_vld_q, map_vld_d;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_wvld_q;

  logic                 cmd_fire;
  logic                 rsp_fire;
  logic [COUNT_W-1:0]   cfg_sat;
  logic [WIDX_W-1:0]    first_w;
  logic [BLK_W-1:0]     last_blk;
  logic [WIDX_W-1:0]    last_w;
  logic [BLK_W-1:0]     bc_last;
  logic [WIDX_W-1:0]    find_last_w;
  logic [WIDX_W-1:0]    iss_last_w;
  logic [COUNT_W:0]     sum_end;
  logic [COUNT_W-1:0]   clip_end;
  logic [WORD_BITS-1:0] eff_word;
  logic [BIT_W-1:0]     lo_bit;
  logic [BIT_W-1:0]     hi_bit;
  logic [WORD_BITS-1:0] rng_mask;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  fit_t                 fit;
  logic [COUNT_W-1:0]   fit_end;
  logic [BLK_W-1:0]     fit_start;

  assign cfg_i.ready       = 1'b1;
  assign cmd_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.check_ok    = out_ok_q;
  assign rsp_o.found_block = out_found_q;

  assign cmd_fire = cmd_i.valid && cmd_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;
  assign cfg_sat  = (cfg_i.block_count > COUNT_W'(MAX_BLOCKS)) ?
                    COUNT_W'(MAX_BLOCKS) : cfg_i.block_count;

  assign first_w     = start_q[BLK_W-1 -: WIDX_W];
  assign last_blk    = BLK_W'(end_q - COUNT_W'(1));
  assign last_w      = last_blk[BLK_W-1 -: WIDX_W];
  assign bc_last     = BLK_W'(bc_q - COUNT_W'(1));
  assign find_last_w = bc_last[BLK_W-1 -: WIDX_W];
  assign iss_last_w  = (state_q == ST_FIND) ? find_last_w : last_w;

  assign sum_end  = {2'b00, start_q} + {1'b0, len_q};
  assign clip_end = (sum_end > {1'b0, bc_q}) ? bc_q : sum_end[COUNT_W-1:0];

  // words never written since reset read as all free
  assign eff_word = rd_wvld_q ? rd_data_q : '0;

  assign lo_bit   = (rd_word_q == first_w) ? start_q[BIT_W-1:0] : '0;
  assign hi_bit   = (rd_word_q == last_w) ? last_blk[BIT_W-1:0] : '1;
  assign rng_mask = ({WORD_BITS{1'b1}} << lo_bit) &
                    ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));
  assign wr_data  = (cmd_q == CMD_CLEAR) ? (eff_word & ~rng_mask) : (eff_word | rng_mask);

  bba_fit_scan u_fit (
    .word_i (eff_word),
    .widx_i (rd_word_q),
    .run_i  (run_q),
    .len_i  (len_q),
    .bc_i   (bc_q),
    .fit_o  (fit)
  );

  assign fit_end   = COUNT_W'({rd_word_q, fit.idx}) + COUNT_W'(1);
  assign fit_start = BLK_W'(fit_end - len_q);

  always_comb begin
    state_d     = state_q;
    bc_d        = bc_q;
    cmd_d       = cmd_q;
    start_d     = start_q;
    len_d       = len_q;
    pol_d       = pol_q;
    end_d       = end_q;
    ok_d        = ok_q;
    found_d     = found_q;
    run_d       = run_q;
    iss_d       = iss_q;
    rd_ptr_d    = rd_ptr_q;
    rd_vld_d    = 1'b0;
    rd_word_d   = rd_ptr_q;
    out_vld_d   = out_vld_q;
    out_ok_d    = out_ok_q;
    out_found_d = out_found_q;
    map_vld_d   = map_vld_q;
    wr_en       = 1'b0;

    if (cfg_i.valid && cfg_i.ready) begin
      bc_d = cfg_sat;
    end

    // one word read issued per cycle, data back the next cycle
    if (iss_q) begin
      rd_vld_d = 1'b1;
      rd_ptr_d = rd_ptr_q + WIDX_W'(1);
      if (rd_ptr_q == iss_last_w) begin
        iss_d = 1'b0;
      end
    end

    if (rsp_fire) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          cmd_d   = cmd_i.command;
          start_d = cmd_i.start_block;
          len_d   = cmd_i.length;
          pol_d   = cmd_i.polarity;
          ok_d    = 1'b1;
          found_d = '0;
          if (cmd_i.command == CMD_FIND) begin
            if (cmd_i.length == '0 || bc_q == '0) begin
              state_d = ST_RESP;
            end else begin
              found_d  = bc_q;
              run_d    = '0;
              rd_ptr_d = '0;
              iss_d    = 1'b1;
              state_d  = ST_FIND;
            end
          end else begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        end_d = clip_end;
        if (clip_end <= COUNT_W'(start_q)) begin
          state_d = ST_RESP;
        end else begin
          rd_ptr_d = first_w;
          iss_d    = 1'b1;
          state_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (rd_vld_q) begin
          if (cmd_q != CMD_CHECK) begin
            wr_en                = 1'b1;
            map_vld_d[rd_word_q] = 1'b1;
          end else if (((eff_word ^ {WORD_BITS{pol_q}}) & rng_mask) != '0) begin
            ok_d = 1'b0;
          end
          if (rd_word_q == last_w) begin
            state_d = ST_RESP;
          end
        end
      end
      ST_FIND: begin
        if (rd_vld_q) begin
          if (fit.hit) begin
            // run found: mark it used with a set pass
            found_d  = COUNT_W'(fit_start);
            start_d  = fit_start;
            iss_d    = 1'b0;
            rd_vld_d = 1'b0;
            state_d  = ST_SETUP;
          end else begin
            run_d = fit.run_out;
            if (rd_word_q == find_last_w) begin
              state_d = ST_RESP;
            end
          end
        end
      end
      ST_RESP: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d   = 1'b1;
          out_ok_d    = (cmd_q == CMD_CHECK) && ok_q;
          out_found_d = (cmd_q == CMD_FIND) ? found_q : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bc_q      <= COUNT_W'(MAX_BLOCKS);
      iss_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      map_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      bc_q      <= bc_d;
      iss_q     <= iss_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      map_vld_q <= map_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    start_q     <= start_d;
    len_q       <= len_d;
    pol_q       <= pol_d;
    end_q       <= end_d;
    ok_q        <= ok_d;
    found_q     <= found_d;
    run_q       <= run_d;
    rd_ptr_q    <= rd_ptr_d;
    rd_word_q   <= rd_word_d;
    out_ok_q    <= out_ok_d;
    out_found_q <= out_found_d;
  end

  // bitmap RAM
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[rd_word_q] <= wr_data;
    end
    rd_data_q <= mem[rd_ptr_q];
    rd_wvld_q <= map_vld_q[rd_ptr_q];
  end

  a_wr_only_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_RUN) && (cmd_q != CMD_CHECK))
    else $error("map write outside a set/clear pass");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!iss_q && !rd_vld_q))
    else $error("map reads still in flight while idle");

  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_fire |=> (state_q == ST_SETUP || state_q == ST_FIND || state_q == ST_RESP))
    else $error("accepted transaction did not start");

  a_rsp_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_RESP))
    else $error("response raised outside the response state");

  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_found_q <= bc_q))
    else $error("found block beyond block count");

endmodule

`default_nettype wire

### dv/bitmap_block_allocator_test.sv
`timescale 1ns / 100ps

module bitmap_block_allocator_test;
  import bba_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 75;
  localparam int unsigned N_DIRECTED = 26;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned IDLE_PCT = 26;

  typedef struct packed {
    logic               check_ok;
    logic [COUNT_W-1:0] found_block;
  } alloc_result_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

  // for ROW_CFG rows the new block_count travels in len
  typedef struct packed {
    row_kind_e          kind;
    cmd_e               op;
    logic [BLK_W-1:0]   first;
    logic [COUNT_W-1:0] len;
    logic               pol;
    logic               typed;
    alloc_result_t      want;
  } step_t;

  localparam step_t DIRECTED_STEPS [N_DIRECTED] = '{
    '{ROW_CMD, CMD_CHECK, 12'd0,    13'd4096, 1'b0, 1'b1, '{1'b1, 13'd0}},
    '{ROW_CMD, CMD_CHECK, 12'd0,    13'd4096, 1'b1, 1'b1, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_FIND,  12'd4095, 13'd0,    1'b0, 1'b1, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_FIND,  12'd0,    13'd1,    1'b1, 1'b1, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_FIND,  12'd0,    13'd4096, 1'b0, 1'b1, '{1'b0, 13'd4096}},
    '{ROW_CMD, CMD_SET,   12'd4095, 13'd8191, 1'b1, 1'b1, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_CHECK, 12'd4095, 13'd8191, 1'b1, 1'b1, '{1'b1, 13'd0}},
    '{ROW_CMD, CMD_CHECK, 12'd4000, 13'd0,    1'b1, 1'b1, '{1'b1, 13'd0}},
    '{ROW_CMD, CMD_SET,   12'd64,   13'd40,   1'b0, 1'b0, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_FIND,  12'd0,    13'd63,   1'b0, 1'b0, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_FIND,  12'd0,    13'd2,    1'b0, 1'b0, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_CHECK, 12'd1,    13'd103,  1'b1, 1'b0, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_CLEAR, 12'd0,    13'd4096, 1'b1, 1'b1, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_FIND,  12'd0,    13'd4096, 1'b0, 1'b1, '{1'b0, 13'd0}},
    '{ROW_CFG, CMD_SET,   12'd0,    13'd40,   1'b0, 1'b0, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_CHECK, 12'd0,    13'd4096, 1'b1, 1'b0, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_CLEAR, 12'd30,   13'd20,   1'b0, 1'b0, '{1'b0, 13'd0}},
    '{ROW_CFG, CMD_SET,   12'd0,    13'd8191, 1'b0, 1'b0, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_CHECK, 12'd40,   13'd4056, 1'b1, 1'b0, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_FIND,  12'd0,    13'd1,    1'b0, 1'b0, '{1'b0, 13'd0}},
    '{ROW_CFG, CMD_SET,   12'd0,    13'd0,    1'b0, 1'b0, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_FIND,  12'd0,    13'd0,    1'b0, 1'b1, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_FIND,  12'd0,    13'd7,    1'b0, 1'b1, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_SET,   12'd0,    13'd10,   1'b0, 1'b1, '{1'b0, 13'd0}},
    '{ROW_CMD, CMD_CHECK, 12'd0,    13'd10,   1'b0, 1'b1, '{1'b1, 13'd0}},
    '{ROW_CFG, CMD_SET,   12'd0,    13'd4096, 1'b0, 1'b0, '{1'b0, 13'd0}}
  };

  // block_count per random phase: extremes, saturation, odd sizes
  localparam logic [COUNT_W-1:0] PHASE_COUNTS [N_PHASES] = '{
    13'd4096, 13'd1, 13'd33, 13'd5000, 13'd0, 13'd4095, 13'd200, 13'd8191
  };

  logic clk_i;
  logic rst_ni;

  bba_cfg_if cfg_bus ();
  bba_cmd_if cmd_bus ();
  bba_rsp_if rsp_bus ();

  bitmap_block_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .cmd_i  (cmd_bus),
    .rsp_o  (rsp_bus)
  );

  // model state
  bit          used_bits [MAX_BLOCKS];
  int unsigned managed_blocks;
  alloc_result_t replies_due [$];

  // typed-in expectation riding along with the command fields
  logic          row_typed;
  alloc_result_t row_want;

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned idle_pct;
  bit          hold_request;
  int unsigned hold_left;

  always #1 clk_i = ~clk_i;

  function automatic void load_block_count(logic [COUNT_W-1:0] value);
    managed_blocks = (value > MAX_BLOCKS) ? MAX_BLOCKS : value;
  endfunction

  function automatic void mark_blocks(int unsigned first, int unsigned len, bit val);
    for (int unsigned i = 0; i < len; i++) begin
      if (first + i >= managed_blocks) return;
      used_bits[first + i] = val;
    end
  endfunction

  function automatic bit blocks_all_match(int unsigned first, int unsigned len, bit val);
    for (int unsigned i = 0; i < len; i++) begin
      if (first + i >= managed_blocks) return 1'b1;
      if (used_bits[first + i] != val) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned next_block_with(int unsigned from, bit val);
    for (int unsigned i = from; i < managed_blocks; i++)
      if (used_bits[i] == val) return i;
    return managed_blocks;
  endfunction

  function automatic int unsigned first_free_run(int unsigned len);
    int unsigned cur;
    int unsigned next_used;
    cur = 0;
    while (cur < managed_blocks) begin
      next_used = next_block_with(cur, 1'b1);
      if (next_used - cur >= len) begin
        mark_blocks(cur, len, 1'b1);
        return cur;
      end
      cur = next_block_with(next_used, 1'b0);
    end
    return managed_blocks;
  endfunction

  function automatic alloc_result_t apply_command(cmd_e op, logic [BLK_W-1:0] first,
                                                  logic [COUNT_W-1:0] len, logic pol);
    alloc_result_t res;
    res = '0;
    case (op)
      CMD_SET: begin
        mark_blocks(first, len, 1'b1);
      end
      CMD_CLEAR: begin
        mark_blocks(first, len, 1'b0);
      end
      CMD_CHECK: begin
        res.check_ok = blocks_all_match(first, len, pol);
      end
      default: begin
        res.found_block = COUNT_W'(first_free_run(len));
      end
    endcase
    return res;
  endfunction

  // response check first: a reply never belongs to a command taken at the same edge
  always @(posedge clk_i) begin : track_transactions
    alloc_result_t want;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (replies_due.size() == 0) begin
          $error("response with no command outstanding");
          error_count++;
        end else begin
          want = replies_due.pop_front();
          if (rsp_bus.check_ok !== want.check_ok) begin
            $error("check_ok: expected %0d, actual %0d", want.check_ok, rsp_bus.check_ok);
            error_count++;
          end
          if (rsp_bus.found_block !== want.found_block) begin
            $error("found_block: expected %0d, actual %0d", want.found_block,
                   rsp_bus.found_block);
            error_count++;
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready)
        load_block_count(cfg_bus.block_count);
      if (cmd_bus.valid && cmd_bus.ready) begin
        want = apply_command(cmd_e'(cmd_bus.command), cmd_bus.start_block, cmd_bus.length,
                             cmd_bus.polarity);
        replies_due.push_back(row_typed ? row_want : want);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bitmap_block_allocator test failed");
      $finish;
    end
  end

  task automatic issue_command(cmd_e op, logic [BLK_W-1:0] first, logic [COUNT_W-1:0] len,
                               logic pol, logic typed, alloc_result_t want);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.command     <= op;
    cmd_bus.start_block <= first;
    cmd_bus.length      <= len;
    cmd_bus.polarity    <= pol;
    row_typed           <= typed;
    row_want            <= want;
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  task automatic drain_replies();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk_i); while (replies_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_block_count(logic [COUNT_W-1:0] value);
    drain_replies();
    cfg_bus.valid       <= 1'b1;
    cfg_bus.block_count <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n_items);
    int unsigned pick;
    int unsigned first;
    int unsigned len;
    int unsigned last_first;
    int unsigned last_len;
    bit          have_last;
    have_last = 1'b0;
    last_first = 0;
    last_len = 0;
    for (int unsigned n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(32);
      else if (pick < 90) len = $urandom_range(256);
      else if (pick < 97) len = $urandom_range(MAX_BLOCKS);
      else len = $urandom_range(8191);
      if (managed_blocks > 0 && $urandom_range(99) < 85)
        first = $urandom_range(managed_blocks - 1);
      else
        first = $urandom_range(MAX_BLOCKS - 1);
      pick = $urandom_range(99);
      if (pick < 3) begin
        // wipe the map so later searches keep finding room
        issue_command(CMD_CLEAR, '0, COUNT_W'(MAX_BLOCKS), 1'($urandom_range(1)), 1'b0, '0);
      end else if (pick < 15 && have_last) begin
        issue_command(CMD_CHECK, BLK_W'(last_first), COUNT_W'(last_len),
                      1'($urandom_range(3) != 0), 1'b0, '0);
      end else if (pick < 22 && have_last) begin
        issue_command(CMD_CLEAR, BLK_W'(last_first), COUNT_W'(last_len),
                      1'($urandom_range(1)), 1'b0, '0);
        have_last = 1'b0;
      end else if (pick < 50) begin
        issue_command(CMD_FIND, BLK_W'($urandom()), COUNT_W'(len),
                      1'($urandom_range(1)), 1'b0, '0);
      end else if (pick < 65) begin
        issue_command(CMD_SET, BLK_W'(first), COUNT_W'(len), 1'($urandom_range(1)), 1'b0, '0);
        last_first = first;
        last_len = len;
        have_last = 1'b1;
      end else if (pick < 80) begin
        issue_command(CMD_CLEAR, BLK_W'(first), COUNT_W'(len),
                      1'($urandom_range(1)), 1'b0, '0);
      end else begin
        issue_command(CMD_CHECK, BLK_W'(first), COUNT_W'(len),
                      1'($urandom_range(1)), 1'b0, '0);
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.block_count = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.command = CMD_SET;
    cmd_bus.start_block = '0;
    cmd_bus.length = '0;
    cmd_bus.polarity = 1'b0;
    rsp_bus.ready = 1'b0;
    row_typed = 1'b0;
    row_want = '0;
    error_count = 0;
    cycle_count = 0;
    idle_pct = IDLE_PCT;
    hold_request = 1'b0;
    hold_left = 0;
    foreach (used_bits[i]) used_bits[i] = 1'b0;
    managed_blocks = MAX_BLOCKS;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_STEPS[i]) begin
      if (DIRECTED_STEPS[i].kind == ROW_CFG)
        write_block_count(DIRECTED_STEPS[i].len);
      else
        issue_command(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].first, DIRECTED_STEPS[i].len,
                      DIRECTED_STEPS[i].pol, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
    end

    for (int unsigned p = 0; p < N_PHASES; p++) begin
      write_block_count(PHASE_COUNTS[p]);
      // phase 0 runs back to back on both sides
      idle_pct = (p == 0) ? 0 : IDLE_PCT;
      // phase 2: receiver stalls long enough for the command side to back up
      if (p == 2) hold_request = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    drain_replies();
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && replies_due.size() == 0) begin
      $display("bitmap_block_allocator test passed");
    end else begin
      $display("bitmap_block_allocator test failed");
    end
    $finish;
  end

endmodule
